@@ rtl/v3alu_pkg.sv @@
`timescale 1ns / 1ps

package v3alu_pkg;

   // Fixed-point format
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int MODE_W    = 3;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int AS_W      = DATA_W + 1;
   localparam int ACC_W     = PROD_W + 2;
   localparam int D_W       = PROD_W;

   // Square root: one result bit per stage
   localparam int SQ_STEPS = D_W / 2;
   localparam int SQ_LAT   = SQ_STEPS;

   // Divider: quotient never exceeds 2^FRAC_BITS
   localparam int QUO_W   = FRAC_BITS + 1;
   localparam int NUM_W   = DATA_W + FRAC_BITS;
   localparam int DIV_LAT = QUO_W + 1;

   // Pipeline bookkeeping
   localparam int SIDE_N = SQ_LAT + DIV_LAT;
   localparam int VLD_N  = SIDE_N + 2;
   localparam int MAG_N  = SQ_LAT + 1;

   localparam logic [DATA_W-1:0] THR_RESET = DATA_W'(43);

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD   = 3'd0,
      MODE_SUB   = 3'd1,
      MODE_SCALE = 3'd2,
      MODE_DOT   = 3'd3,
      MODE_CROSS = 3'd4,
      MODE_NORM  = 3'd5,
      MODE_ZTEST = 3'd6
   } mode_type;

   // Products of one lane
   typedef struct packed {
      logic [PROD_W-1:0]        aa;
      logic signed [PROD_W-1:0] mx;
      logic signed [PROD_W-1:0] cp;
      logic signed [PROD_W-1:0] cq;
      logic signed [AS_W-1:0]   as;
      logic [DATA_W-1:0]        mag;
      logic                     neg;
   } lane_prod_type;

   // Finished non-normalize result riding beside the sqrt/divide pipe
   typedef struct packed {
      logic [2:0][DATA_W-1:0] r;
      logic [2:0]             neg;
      logic                   sat;
      logic                   zero;
      logic                   is_norm;
      logic                   norm_ok;
   } side_type;

   typedef struct packed {
      logic [DATA_W-1:0] r_x;
      logic [DATA_W-1:0] r_y;
      logic [DATA_W-1:0] r_z;
      logic              is_zero;
      logic              saturated;
   } result_type;

endpackage

@@ rtl/v3alu_req_if.sv @@
`timescale 1ns / 1ps

interface v3alu_req_if;
   import v3alu_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic signed [DATA_W-1:0] a_x;
   logic signed [DATA_W-1:0] a_y;
   logic signed [DATA_W-1:0] a_z;
   logic signed [DATA_W-1:0] b_x;
   logic signed [DATA_W-1:0] b_y;
   logic signed [DATA_W-1:0] b_z;
   logic signed [DATA_W-1:0] scalar;

   modport source (output valid, mode, a_x, a_y, a_z, b_x, b_y, b_z, scalar, input ready);
   modport sink   (input valid, mode, a_x, a_y, a_z, b_x, b_y, b_z, scalar, output ready);
endinterface

@@ rtl/v3alu_rsp_if.sv @@
`timescale 1ns / 1ps

interface v3alu_rsp_if;
   import v3alu_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] r_x;
   logic signed [DATA_W-1:0] r_y;
   logic signed [DATA_W-1:0] r_z;
   logic                     is_zero;
   logic                     saturated;

   modport source (output valid, r_x, r_y, r_z, is_zero, saturated, input ready);
   modport sink   (input valid, r_x, r_y, r_z, is_zero, saturated, output ready);
endinterface

@@ rtl/v3alu_csr_if.sv @@
`timescale 1ns / 1ps

interface v3alu_csr_if;
   import v3alu_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ rtl/v3alu_lane.sv @@
`timescale 1ns / 1ps

// One vector component: all products this component needs, registered.
module v3alu_lane (
   input  logic                               clock,
   input  logic                               en,
   input  logic [v3alu_pkg::MODE_W-1:0]       mode,
   input  logic signed [v3alu_pkg::DATA_W-1:0] a_self,
   input  logic signed [v3alu_pkg::DATA_W-1:0] a_next,
   input  logic signed [v3alu_pkg::DATA_W-1:0] a_far,
   input  logic signed [v3alu_pkg::DATA_W-1:0] b_self,
   input  logic signed [v3alu_pkg::DATA_W-1:0] b_next,
   input  logic signed [v3alu_pkg::DATA_W-1:0] b_far,
   input  logic signed [v3alu_pkg::DATA_W-1:0] scalar,
   output v3alu_pkg::lane_prod_type           prod
);
   import v3alu_pkg::*;

   logic signed [DATA_W-1:0] mul_b;
   logic signed [PROD_W-1:0] aa;
   lane_prod_type            prod_in;
   lane_prod_type            prod_ff;

   assign mul_b = (mode == MODE_SCALE) ? scalar : b_self;
   assign aa    = PROD_W'(a_self) * PROD_W'(a_self);

   always_comb begin
      prod_in.aa  = aa;
      prod_in.mx  = PROD_W'(a_self) * PROD_W'(mul_b);
      prod_in.cp  = PROD_W'(a_next) * PROD_W'(b_far);
      prod_in.cq  = PROD_W'(a_far) * PROD_W'(b_next);
      prod_in.as  = (mode == MODE_SUB) ? (AS_W'(a_self) - AS_W'(b_self))
                                       : (AS_W'(a_self) + AS_W'(b_self));
      prod_in.neg = a_self[DATA_W-1];
      prod_in.mag = a_self[DATA_W-1] ? (~a_self + DATA_W'(1)) : a_self;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;
endmodule

@@ rtl/v3alu_isqrt.sv @@
`timescale 1ns / 1ps

// Pipelined integer square root, one result bit per stage.
module v3alu_isqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [v3alu_pkg::D_W-1:0]     d,
   output logic [v3alu_pkg::DATA_W-1:0]  root
);
   import v3alu_pkg::*;

   logic [D_W-1:0] n_ff   [SQ_STEPS];
   logic [D_W-1:0] res_ff [SQ_STEPS];
   logic [D_W-1:0] n_src  [SQ_STEPS];
   logic [D_W-1:0] r_src  [SQ_STEPS];
   logic [D_W-1:0] trial  [SQ_STEPS];
   logic [D_W-1:0] n_in   [SQ_STEPS];
   logic [D_W-1:0] res_in [SQ_STEPS];

   always_comb begin
      n_src[0] = d;
      r_src[0] = '0;
      for (int j = 1; j < SQ_STEPS; j++) begin
         n_src[j] = n_ff[j-1];
         r_src[j] = res_ff[j-1];
      end
      for (int j = 0; j < SQ_STEPS; j++) begin
         trial[j] = r_src[j] + (D_W'(1) << (D_W - 2 - 2 * j));
         if (n_src[j] >= trial[j]) begin
            n_in[j]   = n_src[j] - trial[j];
            res_in[j] = (r_src[j] >> 1) + (D_W'(1) << (D_W - 2 - 2 * j));
         end else begin
            n_in[j]   = n_src[j];
            res_in[j] = r_src[j] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < SQ_STEPS; j++) begin
            n_ff[j]   <= n_in[j];
            res_ff[j] <= res_in[j];
         end
      end
   end

   assign root = res_ff[SQ_STEPS-1][DATA_W-1:0];
endmodule

@@ rtl/v3alu_div.sv @@
`timescale 1ns / 1ps

// Rounded (mag << F) / root, restoring, one quotient bit per stage.
module v3alu_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [v3alu_pkg::DATA_W-1:0]  mag,
   input  logic [v3alu_pkg::DATA_W-1:0]  root,
   output logic [v3alu_pkg::QUO_W-1:0]   quo
);
   import v3alu_pkg::*;

   logic [NUM_W-1:0]  num_ff;
   logic [DATA_W-1:0] dv0_ff;

   logic [DATA_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0]  low_ff [QUO_W];
   logic [QUO_W-1:0]  quo_ff [QUO_W];
   logic [DATA_W-1:0] dv_ff  [QUO_W];

   logic [DATA_W-1:0] rem_src [QUO_W];
   logic [QUO_W-1:0]  low_src [QUO_W];
   logic [QUO_W-1:0]  quo_src [QUO_W];
   logic [DATA_W-1:0] dv_src  [QUO_W];
   logic [DATA_W:0]   part    [QUO_W];
   logic              ge      [QUO_W];
   logic [DATA_W-1:0] rem_in  [QUO_W];

   always_comb begin
      rem_src[0] = {1'b0, num_ff[NUM_W-1:QUO_W]};
      low_src[0] = num_ff[QUO_W-1:0];
      quo_src[0] = '0;
      dv_src[0]  = dv0_ff;
      for (int j = 1; j < QUO_W; j++) begin
         rem_src[j] = rem_ff[j-1];
         low_src[j] = low_ff[j-1];
         quo_src[j] = quo_ff[j-1];
         dv_src[j]  = dv_ff[j-1];
      end
      for (int j = 0; j < QUO_W; j++) begin
         part[j]   = {rem_src[j], low_src[j][QUO_W-1]};
         ge[j]     = part[j] >= {1'b0, dv_src[j]};
         rem_in[j] = ge[j] ? DATA_W'(part[j] - {1'b0, dv_src[j]}) : part[j][DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= {mag, {FRAC_BITS{1'b0}}} + NUM_W'(root[DATA_W-1:1]);
         dv0_ff <= root;
         for (int j = 0; j < QUO_W; j++) begin
            rem_ff[j] <= rem_in[j];
            low_ff[j] <= low_src[j] << 1;
            quo_ff[j] <= {quo_src[j][QUO_W-2:0], ge[j]};
            dv_ff[j]  <= dv_src[j];
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];
endmodule

@@ rtl/vec3_vector_alu_core.sv @@
`timescale 1ns / 1ps
// Results leave the end of the pipe through the output buffer and are shown on rsp_chan.
// Throughput: one item per cycle; the whole pipe advances together and holds
// only while the two-entry output buffer is full.
// Depth is set by the 32-stage square root and the 18-stage divider of normalize.
// Reset: synchronous, clears valid bits, empties output buffer, zero_threshold back to 43.
module vec3_vector_alu_core (
   input  logic        clock,
   input  logic        reset,
   v3alu_req_if.sink   req_chan,
   v3alu_rsp_if.source rsp_chan,
   v3alu_csr_if.sink   csr_chan
);
   import v3alu_pkg::*;

   localparam logic [1:0] BUF_FULL = 2'd2;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic [QUO_W-1:0] QUO_ONE = QUO_W'(1) << FRAC_BITS;

   // ---------------------------------------------------------------
   // Control: the entire pipe moves when the output buffer has room
   // ---------------------------------------------------------------
   logic              adv;
   logic [VLD_N-1:0]  vld_ff;
   logic [DATA_W-1:0] thr_ff;

   logic [1:0]        cnt_ff;
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   result_type        buf_ff [2];
   logic              push;
   logic              pop;
   result_type        out_in;

   assign adv            = (cnt_ff != BUF_FULL);
   assign req_chan.ready = adv;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         thr_ff <= THR_RESET;
      end else begin
         if (adv) begin
            vld_ff <= {vld_ff[VLD_N-2:0], req_chan.valid};
         end
         if (csr_chan.valid) begin
            thr_ff <= csr_chan.data;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: three lanes form every product in parallel
   // ---------------------------------------------------------------
   lane_prod_type     prod [3];
   logic [MODE_W-1:0] mode1_ff;

   v3alu_lane u_lane_x (
      .clock  (clock),
      .en     (adv),
      .mode   (req_chan.mode),
      .a_self (req_chan.a_x),
      .a_next (req_chan.a_y),
      .a_far  (req_chan.a_z),
      .b_self (req_chan.b_x),
      .b_next (req_chan.b_y),
      .b_far  (req_chan.b_z),
      .scalar (req_chan.scalar),
      .prod   (prod[0])
   );

   v3alu_lane u_lane_y (
      .clock  (clock),
      .en     (adv),
      .mode   (req_chan.mode),
      .a_self (req_chan.a_y),
      .a_next (req_chan.a_z),
      .a_far  (req_chan.a_x),
      .b_self (req_chan.b_y),
      .b_next (req_chan.b_z),
      .b_far  (req_chan.b_x),
      .scalar (req_chan.scalar),
      .prod   (prod[1])
   );

   v3alu_lane u_lane_z (
      .clock  (clock),
      .en     (adv),
      .mode   (req_chan.mode),
      .a_self (req_chan.a_z),
      .a_next (req_chan.a_x),
      .a_far  (req_chan.a_y),
      .b_self (req_chan.b_z),
      .b_next (req_chan.b_x),
      .b_far  (req_chan.b_y),
      .scalar (req_chan.scalar),
      .prod   (prod[2])
   );

   // ---------------------------------------------------------------
   // Stage 2: merge lanes into exact sums (pre-rounding, 2F fraction bits).
   // Add/sub are pre-shifted so the common rounding step leaves them exact.
   // ---------------------------------------------------------------
   logic [MODE_W-1:0]        mode2_ff;
   logic [D_W-1:0]           d_ff;
   logic [D_W-1:0]           d_in;
   logic signed [ACC_W-1:0]  v_ff [3];
   logic signed [ACC_W-1:0]  v_in [3];
   logic [2:0]               neg2_ff;
   logic [2:0][DATA_W-1:0]   mag_dly_ff [MAG_N];

   assign d_in = prod[0].aa + prod[1].aa + prod[2].aa;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v_in[i] = '0;
      end
      case (mode1_ff)
         MODE_ADD, MODE_SUB: begin
            for (int i = 0; i < 3; i++) begin
               v_in[i] = ACC_W'($signed(prod[i].as)) <<< FRAC_BITS;
            end
         end
         MODE_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               v_in[i] = ACC_W'($signed(prod[i].mx));
            end
         end
         MODE_DOT: begin
            v_in[0] = ACC_W'($signed(prod[0].mx)) + ACC_W'($signed(prod[1].mx))
                    + ACC_W'($signed(prod[2].mx));
         end
         MODE_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               v_in[i] = ACC_W'($signed(prod[i].cp)) - ACC_W'($signed(prod[i].cq));
            end
         end
         default: begin
            // normalize is filled in at the end; zero test stays zero
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Stage 3: round half up, saturate, zero test against threshold
   // ---------------------------------------------------------------
   side_type                side_ff [SIDE_N];
   side_type                side_in;
   logic signed [ACC_W-1:0] rnd [3];
   logic [ACC_W-DATA_W:0]   rnd_hi [3];
   logic [2:0]              ovf_pos;
   logic [2:0]              ovf_neg;

   always_comb begin
      side_in.zero    = d_ff < D_W'(thr_ff);
      side_in.is_norm = (mode2_ff == MODE_NORM);
      side_in.norm_ok = side_in.is_norm && !side_in.zero && (d_ff != '0);
      side_in.neg     = neg2_ff;
      for (int i = 0; i < 3; i++) begin
         rnd[i]     = (v_ff[i] + ROUND_HALF) >>> FRAC_BITS;
         rnd_hi[i]  = rnd[i][ACC_W-1:DATA_W-1];
         ovf_pos[i] = !rnd[i][ACC_W-1] && (rnd_hi[i] != '0);
         ovf_neg[i] = rnd[i][ACC_W-1] && !(&rnd_hi[i]);
         if (ovf_pos[i]) begin
            side_in.r[i] = {1'b0, {(DATA_W-1){1'b1}}};
         end else if (ovf_neg[i]) begin
            side_in.r[i] = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            side_in.r[i] = rnd[i][DATA_W-1:0];
         end
      end
      side_in.sat = |(ovf_pos | ovf_neg);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mode1_ff <= req_chan.mode;
         mode2_ff <= mode1_ff;
         d_ff     <= d_in;
         for (int i = 0; i < 3; i++) begin
            v_ff[i]          <= v_in[i];
            neg2_ff[i]       <= prod[i].neg;
            mag_dly_ff[0][i] <= prod[i].mag;
         end
         for (int k = 1; k < MAG_N; k++) begin
            mag_dly_ff[k] <= mag_dly_ff[k-1];
         end
         side_ff[0] <= side_in;
         for (int k = 1; k < SIDE_N; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // Normalize: sqrt of the self dot, then three dividers in parallel
   // ---------------------------------------------------------------
   logic [DATA_W-1:0] root;
   logic [QUO_W-1:0]  quo [3];

   v3alu_isqrt u_isqrt (
      .clock (clock),
      .en    (adv),
      .d     (d_ff),
      .root  (root)
   );

   for (genvar i = 0; i < 3; i++) begin : g_div
      v3alu_div u_div (
         .clock (clock),
         .en    (adv),
         .mag   (mag_dly_ff[SQ_LAT][i]),
         .root  (root),
         .quo   (quo[i])
      );
   end

   // ---------------------------------------------------------------
   // Final select into the output buffer
   // ---------------------------------------------------------------
   side_type               side_last;
   logic [2:0][DATA_W-1:0] r_fin;
   logic [DATA_W-1:0]      q_ext [3];

   assign side_last = side_ff[SIDE_N-1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q_ext[i] = DATA_W'(quo[i]);
         if (side_last.is_norm) begin
            if (side_last.norm_ok) begin
               r_fin[i] = side_last.neg[i] ? (~q_ext[i] + DATA_W'(1)) : q_ext[i];
            end else begin
               r_fin[i] = '0;
            end
         end else begin
            r_fin[i] = side_last.r[i];
         end
      end
      out_in.r_x       = r_fin[0];
      out_in.r_y       = r_fin[1];
      out_in.r_z       = r_fin[2];
      out_in.is_zero   = side_last.zero;
      out_in.saturated = side_last.sat;
   end

   assign push = adv && vld_ff[VLD_N-1];
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= out_in;
      end
   end

   assign rsp_chan.valid     = (cnt_ff != '0);
   assign rsp_chan.r_x       = buf_ff[rd_ptr_ff].r_x;
   assign rsp_chan.r_y       = buf_ff[rd_ptr_ff].r_y;
   assign rsp_chan.r_z       = buf_ff[rd_ptr_ff].r_z;
   assign rsp_chan.is_zero   = buf_ff[rd_ptr_ff].is_zero;
   assign rsp_chan.saturated = buf_ff[rd_ptr_ff].saturated;

`ifndef NO_ASSERTIONS
   // buffer never written while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != BUF_FULL))
      else $error("output buffer overflow");

   // normalize never clamps
   a_norm_no_sat: assert property (@(posedge clock) disable iff (reset)
      (push && side_last.is_norm) |-> !side_last.sat)
      else $error("saturation flagged on normalize");

   // unit-vector components stay within one
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (push && side_last.norm_ok) |->
         (quo[0] <= QUO_ONE) && (quo[1] <= QUO_ONE) && (quo[2] <= QUO_ONE))
      else $error("normalize quotient out of range");

   // nothing offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_chan.valid)
      else $error("response valid after reset");
`endif
endmodule

@@ tb/sv/vec3_alu_checker.sv @@
`timescale 1ns / 1ps

module vec3_alu_checker
   import v3alu_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   v3alu_req_if  req_mon,
   v3alu_rsp_if  rsp_mon,
   v3alu_csr_if  csr_mon,
   output int    fail_count,
   output int    outstanding
);

   logic [DATA_W-1:0] threshold;
   result_type        expected_q[$];

   initial fail_count = 0;
   assign outstanding = expected_q.size();

   function automatic logic signed [127:0] round_frac(logic signed [127:0] v);
      return (v + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [DATA_W-1:0] clamp32(logic signed [127:0] v, ref logic sat);
      if (v > 128'sd2147483647) begin
         sat = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -128'sd2147483648) begin
         sat = 1'b1;
         return 32'h8000_0000;
      end
      return v[DATA_W-1:0];
   endfunction

   function automatic result_type vector_result(
      logic [MODE_W-1:0] mode,
      logic signed [DATA_W-1:0] ax, ay, az, bx, by, bz, sc,
      logic [DATA_W-1:0] thr
   );
      logic signed [127:0] a[3];
      logic signed [127:0] b[3];
      logic signed [127:0] r[3];
      logic signed [127:0] s;
      logic [63:0]         self_dot;
      logic [63:0]         root;
      logic [63:0]         mag;
      logic [63:0]         quo;
      logic                sat;
      logic                zero;
      result_type          res;
      a[0] = ax; a[1] = ay; a[2] = az;
      b[0] = bx; b[1] = by; b[2] = bz;
      s = sc;
      r[0] = 0; r[1] = 0; r[2] = 0;
      sat = 1'b0;
      self_dot = 64'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
      zero = self_dot < {32'd0, thr};
      case (mode)
         MODE_ADD:   for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
         MODE_SUB:   for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
         MODE_SCALE: for (int i = 0; i < 3; i++) r[i] = round_frac(a[i] * s);
         MODE_DOT:   r[0] = round_frac(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
         MODE_CROSS: begin
            for (int i = 0; i < 3; i++)
               r[i] = round_frac(a[(i + 1) % 3] * b[(i + 2) % 3]
                                 - a[(i + 2) % 3] * b[(i + 1) % 3]);
         end
         MODE_NORM: begin
            // zero vector (or below threshold) normalizes to zero
            if (!zero && self_dot != 0) begin
               root = int_sqrt(self_dot);
               for (int i = 0; i < 3; i++) begin
                  mag  = a[i] < 0 ? 64'(-a[i]) : 64'(a[i]);
                  quo  = ((mag << FRAC_BITS) + (root >> 1)) / root;
                  r[i] = a[i] < 0 ? -$signed({64'd0, quo}) : $signed({64'd0, quo});
               end
            end
         end
         default: ;
      endcase
      res.r_x       = clamp32(r[0], sat);
      res.r_y       = clamp32(r[1], sat);
      res.r_z       = clamp32(r[2], sat);
      res.is_zero   = zero;
      res.saturated = sat;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      $display("%0t: MISMATCH %s got %h expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         threshold <= THR_RESET;
      end else begin
         if (csr_mon.valid && csr_mon.ready)
            threshold <= csr_mon.data;
         if (req_mon.valid && req_mon.ready)
            expected_q.push_back(vector_result(req_mon.mode, req_mon.a_x, req_mon.a_y,
               req_mon.a_z, req_mon.b_x, req_mon.b_y, req_mon.b_z, req_mon.scalar,
               threshold));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result r_x", rsp_mon.r_x, '0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_mon.r_x !== want.r_x) report_mismatch("r_x", rsp_mon.r_x, want.r_x);
               if (rsp_mon.r_y !== want.r_y) report_mismatch("r_y", rsp_mon.r_y, want.r_y);
               if (rsp_mon.r_z !== want.r_z) report_mismatch("r_z", rsp_mon.r_z, want.r_z);
               if (rsp_mon.is_zero !== want.is_zero)
                  report_mismatch("is_zero", rsp_mon.is_zero, want.is_zero);
               if (rsp_mon.saturated !== want.saturated)
                  report_mismatch("saturated", rsp_mon.saturated, want.saturated);
            end
         end
      end
   end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import v3alu_pkg::*;

   // Q16.16 landmarks
   localparam logic [DATA_W-1:0] MAX_V = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] MIN_V = 32'h8000_0000;
   localparam logic [DATA_W-1:0] ONE_V = 32'h0001_0000;
   localparam logic [DATA_W-1:0] NEG_ONE_V = 32'hFFFF_0000;
   localparam int PIPE_LAT = 52;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   outstanding;
   int   sent_count = 0;
   int   rsp_count = 0;

   // receiver control: a long hold-off request and a no-idle window
   logic long_hold = 1'b0;
   logic rx_no_idle = 1'b0;

   v3alu_req_if req_bus();
   v3alu_rsp_if rsp_bus();
   v3alu_csr_if csr_bus();

   vec3_vector_alu_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source),
      .csr_chan (csr_bus.sink)
   );

   vec3_alu_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_mon     (csr_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   // Known values on every input from time zero
   initial begin
      req_bus.valid  = 1'b0;
      req_bus.mode   = '0;
      req_bus.a_x    = '0;
      req_bus.a_y    = '0;
      req_bus.a_z    = '0;
      req_bus.b_x    = '0;
      req_bus.b_y    = '0;
      req_bus.b_z    = '0;
      req_bus.scalar = '0;
      rsp_bus.ready  = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.data   = '0;
   end

   // Hard limit on the whole run
   initial begin
      #5ms;
      $display("vec3_vector_alu_core test failed");
      $finish;
   end

   // Random component: extremes, unit values, small values or full-range noise
   function automatic logic [DATA_W-1:0] pick_component();
      case ($urandom_range(0, 11))
         0:       return MAX_V;
         1:       return MIN_V;
         2:       return '0;
         3:       return ONE_V;
         4:       return NEG_ONE_V;
         5, 6:    return $urandom;                       // full range, saturates often
         7:       return 32'($signed($urandom_range(0, 255)) - 128);  // tiny, near zero test
         default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      endcase
   endfunction

   // Offer one item after a gap; returns at the edge where it transfers.
   // valid stays high across back-to-back items (gap 0).
   task automatic send_item(logic [MODE_W-1:0] mode,
                            logic [DATA_W-1:0] ax, ay, az, bx, by, bz, sc,
                            int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.mode   <= mode;
      req_bus.a_x    <= ax;
      req_bus.a_y    <= ay;
      req_bus.a_z    <= az;
      req_bus.b_x    <= bx;
      req_bus.b_y    <= by;
      req_bus.b_z    <= bz;
      req_bus.scalar <= sc;
      // ready is sampled mid-cycle, clear of edge ordering
      @(negedge clock);
      while (!req_bus.ready) @(negedge clock);
      @(posedge clock);
      sent_count++;
   endtask

   task automatic send_random(int gap);
      send_item(3'($urandom_range(0, 7)), pick_component(), pick_component(),
                pick_component(), pick_component(), pick_component(),
                pick_component(), pick_component(), gap);
   endtask

   // Drain everything, let the pipe settle, then write the threshold
   task automatic write_threshold(logic [DATA_W-1:0] value);
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (PIPE_LAT + 8) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      @(negedge clock);
      while (!csr_bus.ready) @(negedge clock);
      @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic int draw_gap();
      // about a third of items go back to back
      return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
   endfunction

   // Receiver: random stalls, an occasional long hold-off, no-idle windows
   initial begin
      int wait_n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            wait_n = 300;
            long_hold = 1'b0;
         end else if (rx_no_idle) begin
            wait_n = 0;
         end else begin
            wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
         end
         if (wait_n > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(negedge clock);
         while (!rsp_bus.valid) @(negedge clock);
         @(posedge clock);
         rsp_count++;
      end
   end

   // Stimulus
   initial begin
      logic [DATA_W-1:0] thr_list[5];
      thr_list = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0001_0000, 32'd43};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed set at the reset threshold
      send_item(MODE_ADD,   MAX_V, MAX_V, MIN_V, MAX_V, ONE_V, MIN_V, 0, 0);
      send_item(MODE_ADD,   MIN_V, 0, ONE_V, NEG_ONE_V, 0, NEG_ONE_V, 0, 0);
      send_item(MODE_SUB,   MIN_V, MAX_V, 0, MAX_V, MIN_V, 0, 0, 1);
      send_item(MODE_SUB,   ONE_V, NEG_ONE_V, 5, ONE_V, ONE_V, 7, 0, 0);
      send_item(MODE_SCALE, MAX_V, MIN_V, ONE_V, 0, 0, 0, MAX_V, 0);
      send_item(MODE_SCALE, MIN_V, 32'h0000_8000, 32'hFFFF_8000, 0, 0, 0, MIN_V, 2);
      send_item(MODE_SCALE, 32'd1, 32'd3, 32'hFFFF_FFFF, 0, 0, 0, 32'h0000_8000, 0);
      send_item(MODE_DOT,   MAX_V, MAX_V, MAX_V, MAX_V, MAX_V, MAX_V, 0, 0);
      send_item(MODE_DOT,   MIN_V, MIN_V, MIN_V, MAX_V, MAX_V, MAX_V, 0, 0);
      send_item(MODE_DOT,   ONE_V, 32'd1, 0, NEG_ONE_V, 32'h0000_8000, 0, 0, 3);
      send_item(MODE_CROSS, ONE_V, 0, 0, 0, ONE_V, 0, 0, 0);
      send_item(MODE_CROSS, MAX_V, MIN_V, MAX_V, MIN_V, MAX_V, MIN_V, 0, 0);
      // normalize: exact zero vector, below threshold, unit axis, extremes
      send_item(MODE_NORM,  0, 0, 0, 0, 0, 0, 0, 0);
      send_item(MODE_NORM,  32'd2, 32'd3, 32'd5, 0, 0, 0, 0, 0);
      send_item(MODE_NORM,  32'd3, 32'd3, 32'd3, 0, 0, 0, 0, 1);
      send_item(MODE_NORM,  ONE_V, 0, 0, 0, 0, 0, 0, 0);
      send_item(MODE_NORM,  MIN_V, MIN_V, MIN_V, 0, 0, 0, 0, 0);
      send_item(MODE_NORM,  MAX_V, NEG_ONE_V, 32'd1, 0, 0, 0, 0, 0);
      send_item(MODE_ZTEST, 0, 0, 0, MAX_V, MAX_V, MAX_V, MAX_V, 0);
      send_item(MODE_ZTEST, 32'd6, 32'd1, 0, 0, 0, 0, 0, 0);
      send_item(MODE_ZTEST, MAX_V, MIN_V, ONE_V, 0, 0, 0, 0, 0);
      send_item(3'd7,       ONE_V, ONE_V, ONE_V, ONE_V, ONE_V, ONE_V, ONE_V, 0);
      send_item(3'd7,       0, 0, 0, MIN_V, MIN_V, MIN_V, MIN_V, 0);

      // Random phases, one per threshold setting; extremes included
      for (int ph = 0; ph < 5; ph++) begin
         write_threshold(ph == 4 ? $urandom : thr_list[ph]);
         // the exact zero vector is special when the threshold is zero
         send_item(MODE_NORM, 0, 0, 0, $urandom, $urandom, $urandom, $urandom, 0);
         send_item(MODE_ZTEST, 0, 0, 0, 0, 0, 0, 0, 0);
         if (ph == 1) begin
            // long receiver hold-off while the sender keeps streaming:
            // the output buffer fills and the pipe stalls its input
            long_hold = 1'b1;
            repeat (40) send_random(0);
         end
         if (ph == 2) begin
            // no idling on either side for a stretch
            rx_no_idle = 1'b1;
            repeat (40) send_random(0);
            rx_no_idle = 1'b0;
         end
         repeat (60) send_random(draw_gap());
      end

      // Sender pauses until every result is back, then a final burst
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      write_threshold(32'd43);
      repeat (40) send_random(draw_gap());
      req_bus.valid <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (PIPE_LAT + 8) @(posedge clock);

      $display("Covered %0d vector items over all modes, including unused mode seven,",
               sent_count);
      $display("and %0d results under six threshold settings with stall and burst traffic.",
               rsp_count);
      if (fail_count == 0 && outstanding == 0)
         $display("vec3_vector_alu_core test passed");
      else
         $display("vec3_vector_alu_core test failed");
      $finish;
   end

endmodule

@@ vec3_vector_alu_core.f @@
rtl/v3alu_pkg.sv
rtl/v3alu_req_if.sv
rtl/v3alu_rsp_if.sv
rtl/v3alu_csr_if.sv
rtl/v3alu_lane.sv
rtl/v3alu_isqrt.sv
rtl/v3alu_div.sv
rtl/vec3_vector_alu_core.sv
tb/sv/vec3_alu_checker.sv
tb/sv/tb_top.sv
